>>> hdl/sil_pkg.sv
package sil_pkg;

  localparam int POS_W = 6;
  localparam int VAL_W = 31;
  localparam int IN_W  = 32;
  localparam int OUT_W = 40;

  typedef enum logic {
    FUNC_INSERT  = 1'b0,
    FUNC_DISPLAY = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    KIND_INSERTED = 3'd0,
    KIND_NEGATIVE = 3'd1,
    KIND_FULL     = 3'd2,
    KIND_LISTED   = 3'd3,
    KIND_END      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIST,
    ST_END
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] count;
  } cell_ctl_t;

endpackage

>>> hdl/sil_cell.sv
module sil_cell #(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  sil_pkg::cell_ctl_t       ctl,
  input  logic [sil_pkg::VAL_W-1:0] value,
  input  logic [sil_pkg::VAL_W-1:0] prev_entry,
  input  logic                     prev_s,
  input  logic [sil_pkg::VAL_W-1:0] next_entry,
  input  logic [sil_pkg::VAL_W-1:0] head_entry,
  output logic [sil_pkg::VAL_W-1:0] entry,
  output logic                     s_out
);

  localparam logic [sil_pkg::POS_W-1:0] MY_IDX = sil_pkg::POS_W'(IDX);
  localparam logic [sil_pkg::POS_W-1:0] MY_NUM = sil_pkg::POS_W'(IDX + 1);

  logic occupied;
  logic [sil_pkg::VAL_W-1:0] entry_next;

  assign occupied = MY_IDX < ctl.count;

  // set when the new value lands at or before this cell
  always_comb begin
    if (!occupied) begin
      s_out = 1'b1;
    end else if (IDX == 0) begin
      s_out = value < entry;
    end else begin
      s_out = entry >= value;
    end
  end

  always_comb begin
    entry_next = entry;
    case (ctl.op)
      sil_pkg::CELL_INSERT: begin
        if (s_out) begin
          entry_next = prev_s ? prev_entry : value;
        end
      end
      sil_pkg::CELL_ROTATE: begin
        if (occupied) begin
          entry_next = (MY_NUM == ctl.count) ? head_entry : next_entry;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

>>> hdl/sorted_insert_list_unit.sv
// sorted_insert_list_unit
// keeps up to CAPACITY nonnegative values in ascending order in a row of cells.
// input stream s_*: s_tuser is the operation (0 insert, 1 display), s_tdata the
// value. output stream m_*: one transfer per result, m_tlast on the final one.
// an insert compares the value in every cell at once and shifts the cells
// above the landing slot up by one in the same cycle; its single result is
// registered and shows on m_* in the cycle after the input transfer. inserts
// and rejects sustain one item per cycle while m_tready stays high.
// a display of a nonempty store first moves to the list state; there the
// occupied cells rotate toward cell 0 once per cycle while m_tready stays high,
// and cell 0 is sent out each time, then the end marker follows; the first
// listed entry passes the list state and then the result register. after
// count rotations the cells are back in order. an empty display sends only
// the end marker, in the cycle after the input transfer. no input is taken
// during a display. reset empties the store (count to zero) and drops any
// pending result; cell contents are not cleared. when m_tready is low with a
// result pending, the result register holds, and s_tready drops until the
// result is taken.
module sorted_insert_list_unit #(
  parameter int CAPACITY = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [sil_pkg::IN_W-1:0]    s_tdata,   // value[31:0]
  input  logic [0:0]                  s_tuser,   // func[0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [sil_pkg::OUT_W-1:0]   m_tdata,   // position[5:0], entry_value[36:6], zero
  output logic [2:0]                  m_tuser,   // kind[2:0]
  output logic                        m_tlast
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  sil_pkg::state_t             state, state_next;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            idx, idx_next;
  logic [CNT_W:0]              idx_inc;

  sil_pkg::kind_t              kind_q, ld_kind;
  logic [sil_pkg::POS_W-1:0]   pos_q, ld_pos;
  logic [sil_pkg::VAL_W-1:0]   val_q, ld_val;
  logic                        last_q, ld_last;
  logic                        load;

  logic                        out_free;
  logic                        in_acc;
  logic                        neg;
  logic                        full;
  logic                        do_ins;
  logic [sil_pkg::VAL_W-1:0]   ins_val;
  logic [sil_pkg::POS_W-1:0]   ins_pos;

  sil_pkg::cell_ctl_t          ctl;
  logic [sil_pkg::VAL_W-1:0]   entry [CAPACITY];
  logic [CAPACITY-1:0]         s_vec;
  logic [CAPACITY-1:0]         s_prev;
  logic [CAPACITY-1:0]         s_first;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == sil_pkg::ST_IDLE) && out_free;
  assign in_acc   = s_tvalid && s_tready;
  assign neg      = s_tdata[sil_pkg::IN_W-1];
  assign full     = count == CNT_W'(CAPACITY);
  assign ins_val  = s_tdata[sil_pkg::VAL_W-1:0];
  assign do_ins   = in_acc && (s_tuser[0] == sil_pkg::FUNC_INSERT) && !neg && !full;
  assign idx_inc  = {1'b0, idx} + 1'b1;

  // cell chain
  assign s_prev  = {s_vec[CAPACITY-2:0], 1'b0};
  assign s_first = s_vec & ~s_prev;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [sil_pkg::VAL_W-1:0] prev_e;
      logic [sil_pkg::VAL_W-1:0] next_e;
      if (gi == 0) begin : g_first
        assign prev_e = entry[0];
      end else begin : g_mid
        assign prev_e = entry[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign next_e = entry[0];
      end else begin : g_inner
        assign next_e = entry[gi+1];
      end
      sil_cell #(.IDX(gi)) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .value      (ins_val),
        .prev_entry (prev_e),
        .prev_s     (s_prev[gi]),
        .next_entry (next_e),
        .head_entry (entry[0]),
        .entry      (entry[gi]),
        .s_out      (s_vec[gi])
      );
    end
  endgenerate

  // slot index from the one-hot boundary
  always_comb begin
    ins_pos = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (s_first[k]) begin
        ins_pos = ins_pos | sil_pkg::POS_W'(k);
      end
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    load       = 1'b0;
    ld_kind    = sil_pkg::KIND_INSERTED;
    ld_pos     = '0;
    ld_val     = '0;
    ld_last    = 1'b1;
    ctl.op     = sil_pkg::CELL_HOLD;
    ctl.count  = sil_pkg::POS_W'(count);
    case (state)
      sil_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_tuser[0] == sil_pkg::FUNC_INSERT) begin
            load = 1'b1;
            if (neg) begin
              ld_kind = sil_pkg::KIND_NEGATIVE;
            end else if (full) begin
              ld_kind = sil_pkg::KIND_FULL;
            end else begin
              ld_kind = sil_pkg::KIND_INSERTED;
              ld_pos  = ins_pos;
              ld_val  = ins_val;
              ctl.op  = sil_pkg::CELL_INSERT;
            end
          end else if (count == '0) begin
            load    = 1'b1;
            ld_kind = sil_pkg::KIND_END;
            ld_pos  = sil_pkg::POS_W'(1);
          end else begin
            state_next = sil_pkg::ST_LIST;
            idx_next   = '0;
          end
        end
      end
      sil_pkg::ST_LIST: begin
        if (out_free) begin
          load     = 1'b1;
          ld_kind  = sil_pkg::KIND_LISTED;
          ld_pos   = sil_pkg::POS_W'(idx_inc);
          ld_val   = entry[0];
          ld_last  = 1'b0;
          ctl.op   = sil_pkg::CELL_ROTATE;
          idx_next = idx_inc[CNT_W-1:0];
          if (idx_inc == {1'b0, count}) begin
            state_next = sil_pkg::ST_END;
          end
        end
      end
      sil_pkg::ST_END: begin
        if (out_free) begin
          load       = 1'b1;
          ld_kind    = sil_pkg::KIND_END;
          ld_pos     = sil_pkg::POS_W'(count) + sil_pkg::POS_W'(1);
          state_next = sil_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sil_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sil_pkg::ST_IDLE;
      idx      <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (do_ins) begin
        count <= count + 1'b1;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_q <= ld_kind;
      pos_q  <= ld_pos;
      val_q  <= ld_val;
      last_q <= ld_last;
    end
  end

  assign m_tdata = {{(sil_pkg::OUT_W - sil_pkg::POS_W - sil_pkg::VAL_W){1'b0}}, val_q, pos_q};
  assign m_tuser = kind_q;
  assign m_tlast = last_q;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("count exceeds capacity");

  a_list_idx: assert property (@(posedge clk) disable iff (rst)
    (state == sil_pkg::ST_LIST) |-> (idx < count))
    else $error("list index beyond stored entries");

  a_nonlast_listed: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser == sil_pkg::KIND_LISTED))
    else $error("non-final transfer is not a listed entry");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    do_ins |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the store");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int CAPACITY   = 32;
  localparam int N_DIR      = 16;
  localparam int N_RAND     = 414;
  localparam int N_ITEMS    = N_DIR + N_RAND;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 20;

  typedef struct packed {
    sil_pkg::kind_t            kind;
    logic [sil_pkg::POS_W-1:0] pos;
    logic [sil_pkg::VAL_W-1:0] val;
    logic                      last;
  } list_result_t;

  typedef struct {
    sil_pkg::func_t            f;
    logic [sil_pkg::IN_W-1:0]  v;
    bit                        typed;
    sil_pkg::kind_t            kind;
    logic [sil_pkg::POS_W-1:0] pos;
    logic [sil_pkg::VAL_W-1:0] val;
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [sil_pkg::IN_W-1:0]   s_tdata = '0;    // value[31:0]
  logic [0:0]                 s_tuser = '0;    // func[0]
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [sil_pkg::OUT_W-1:0]  m_tdata;         // position[5:0], entry_value[36:6], zero
  logic [2:0]                 m_tuser;         // kind[2:0]
  logic                       m_tlast;

  dir_row_t                   dir_tab [N_DIR];
  logic [sil_pkg::VAL_W-1:0]  stored [CAPACITY];
  int                         stored_cnt = 0;
  list_result_t               pending_results [$];
  int                         errors = 0;
  int                         sent_cnt = 0;
  int                         burst_left = 0;
  int                         gap_left = 0;
  bit                         drained = 1'b0;
  int                         rx_cyc = 0;
  int                         idle_cyc = 0;

  bit                         fire;
  bit                         nv;
  sil_pkg::func_t             nf;
  logic [sil_pkg::IN_W-1:0]   nd;
  int                         r;
  list_result_t               got;
  list_result_t               want;

  sorted_insert_list_unit #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic predict_item(input sil_pkg::func_t f, input logic [sil_pkg::IN_W-1:0] v,
                              input int idx);
    list_result_t res [$];
    int           slot;
    int           k;
    if (f == sil_pkg::FUNC_INSERT) begin
      if (v[sil_pkg::IN_W-1]) begin
        res.push_back(list_result_t'{sil_pkg::KIND_NEGATIVE, '0, '0, 1'b1});
      end else if (stored_cnt >= CAPACITY) begin
        res.push_back(list_result_t'{sil_pkg::KIND_FULL, '0, '0, 1'b1});
      end else begin
        slot = stored_cnt;
        if (stored_cnt == 0 || v[sil_pkg::VAL_W-1:0] < stored[0]) begin
          slot = 0;
        end else begin
          for (k = stored_cnt - 1; k >= 1; k--)
            if (stored[k] >= v[sil_pkg::VAL_W-1:0]) slot = k;
        end
        for (k = stored_cnt; k > slot; k--)
          stored[k] = stored[k-1];
        stored[slot] = v[sil_pkg::VAL_W-1:0];
        stored_cnt++;
        res.push_back(list_result_t'{sil_pkg::KIND_INSERTED, sil_pkg::POS_W'(slot),
                                     v[sil_pkg::VAL_W-1:0], 1'b1});
      end
    end else begin
      for (k = 0; k < stored_cnt; k++)
        res.push_back(list_result_t'{sil_pkg::KIND_LISTED, sil_pkg::POS_W'(k + 1),
                                     stored[k], 1'b0});
      res.push_back(list_result_t'{sil_pkg::KIND_END, sil_pkg::POS_W'(stored_cnt + 1),
                                   '0, 1'b1});
    end
    if (idx < N_DIR && dir_tab[idx].typed)
      pending_results.push_back(list_result_t'{dir_tab[idx].kind, dir_tab[idx].pos,
                                               dir_tab[idx].val, 1'b1});
    else
      foreach (res[i]) pending_results.push_back(res[i]);
  endtask

  // sender: bursts with random gaps, one pause for a full drain after the directed rows
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      fire = s_tvalid && s_tready;
      if (fire) begin
        predict_item(sil_pkg::func_t'(s_tuser[0]), s_tdata, sent_cnt);
        sent_cnt++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (!s_tvalid || fire) begin
        nv = 1'b0;
        nf = sil_pkg::FUNC_INSERT;
        nd = $urandom;
        if (sent_cnt == N_DIR && !drained) begin
          if (pending_results.size() == 0) drained = 1'b1;
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (sent_cnt < N_ITEMS) begin
          nv = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          if (sent_cnt < N_DIR) begin
            nf = dir_tab[sent_cnt].f;
            nd = dir_tab[sent_cnt].v;
          end else begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
              nd = {1'b1, 31'($urandom)};
            end else if (r < 40) begin
              nf = sil_pkg::FUNC_DISPLAY;
            end else if (r < 70) begin
              nd = $urandom_range(0, 20);
            end else begin
              nd = $urandom & 32'h7FFF_FFFF;
            end
          end
        end
        s_tvalid <= nv;
        s_tdata  <= nd;
        s_tuser  <= nf;
      end
    end
  end

  // receiver: rotating stall patterns
  always @(posedge clk) begin
    rx_cyc++;
    case ((rx_cyc / 97) % 3)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ((rx_cyc % 5) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = '{sil_pkg::kind_t'(m_tuser), m_tdata[sil_pkg::POS_W-1:0],
              m_tdata[sil_pkg::POS_W+sil_pkg::VAL_W-1:sil_pkg::POS_W], m_tlast};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected transfer: kind %0d pos %0d val %0d last %0d",
                 $time, got.kind, got.pos, got.val, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got !== want ||
            m_tdata[sil_pkg::OUT_W-1:sil_pkg::POS_W+sil_pkg::VAL_W] !== '0) begin
          errors++;
          $display("%0t mismatch: exp %0d/%0d/%0h/%0d got %0d/%0d/%0h/%0d pad %0h",
                   $time, want.kind, want.pos, want.val, want.last,
                   got.kind, got.pos, got.val, got.last,
                   m_tdata[sil_pkg::OUT_W-1:sil_pkg::POS_W+sil_pkg::VAL_W]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cyc = 0;
      else
        idle_cyc++;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    dir_tab[0]  = '{sil_pkg::FUNC_DISPLAY, 32'h0000_0000, 1'b1,
                    sil_pkg::KIND_END, 6'd1, 31'd0};
    dir_tab[1]  = '{sil_pkg::FUNC_INSERT, 32'h8000_0000, 1'b1,
                    sil_pkg::KIND_NEGATIVE, 6'd0, 31'd0};
    dir_tab[2]  = '{sil_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 1'b1,
                    sil_pkg::KIND_NEGATIVE, 6'd0, 31'd0};
    dir_tab[3]  = '{sil_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 1'b1,
                    sil_pkg::KIND_INSERTED, 6'd0, 31'h7FFF_FFFF};
    dir_tab[4]  = '{sil_pkg::FUNC_INSERT, 32'h0000_0000, 1'b0,
                    sil_pkg::KIND_INSERTED, 6'd0, 31'd0};
    dir_tab[5]  = '{sil_pkg::FUNC_INSERT, 32'h0000_0000, 1'b0,
                    sil_pkg::KIND_INSERTED, 6'd0, 31'd0};
    dir_tab[6]  = '{sil_pkg::FUNC_INSERT, 32'd100, 1'b0,
                    sil_pkg::KIND_INSERTED, 6'd0, 31'd0};
    dir_tab[7]  = '{sil_pkg::FUNC_INSERT, 32'd100, 1'b0,
                    sil_pkg::KIND_INSERTED, 6'd0, 31'd0};
    dir_tab[8]  = '{sil_pkg::FUNC_INSERT, 32'd50, 1'b0,
                    sil_pkg::KIND_INSERTED, 6'd0, 31'd0};
    dir_tab[9]  = '{sil_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 1'b0,
                    sil_pkg::KIND_INSERTED, 6'd0, 31'd0};
    dir_tab[10] = '{sil_pkg::FUNC_INSERT, 32'h7FFF_FFFE, 1'b0,
                    sil_pkg::KIND_INSERTED, 6'd0, 31'd0};
    dir_tab[11] = '{sil_pkg::FUNC_DISPLAY, 32'h0000_0000, 1'b0,
                    sil_pkg::KIND_END, 6'd0, 31'd0};
    dir_tab[12] = '{sil_pkg::FUNC_INSERT, 32'h8000_0001, 1'b1,
                    sil_pkg::KIND_NEGATIVE, 6'd0, 31'd0};
    dir_tab[13] = '{sil_pkg::FUNC_INSERT, 32'h5555_5555, 1'b0,
                    sil_pkg::KIND_INSERTED, 6'd0, 31'd0};
    dir_tab[14] = '{sil_pkg::FUNC_INSERT, 32'h2AAA_AAAA, 1'b0,
                    sil_pkg::KIND_INSERTED, 6'd0, 31'd0};
    dir_tab[15] = '{sil_pkg::FUNC_DISPLAY, 32'hFFFF_FFFF, 1'b0,
                    sil_pkg::KIND_END, 6'd0, 31'd0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (!(sent_cnt == N_ITEMS && pending_results.size() == 0));
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
